// ----- rtl/jsu_pkg.sv -----
// Package: types, codes and helper functions of the JSON string decoder.
package jsu_pkg;

  localparam int MaxResults = 5;
  localparam int CountW = $clog2(MaxResults + 1);
  localparam int IdxW = $clog2(MaxResults);

  typedef enum logic [3:0] {
    PhIdle,
    PhSkip,
    PhBody,
    PhEsc,
    PhHex1,
    PhLowBs,
    PhLowU,
    PhHex2
  } phase_t;

  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindErr  = 2'd2;

  localparam logic [3:0] ErrNone        = 4'd0;
  localparam logic [3:0] ErrNoQuote     = 4'd1;
  localparam logic [3:0] ErrControl     = 4'd2;
  localparam logic [3:0] ErrTruncEsc    = 4'd3;
  localparam logic [3:0] ErrBadEsc      = 4'd4;
  localparam logic [3:0] ErrTruncUni    = 4'd5;
  localparam logic [3:0] ErrBadHex      = 4'd6;
  localparam logic [3:0] ErrMissingLow  = 4'd7;
  localparam logic [3:0] ErrBadLow      = 4'd8;
  localparam logic [3:0] ErrLoneLow     = 4'd9;
  localparam logic [3:0] ErrNul         = 4'd10;
  localparam logic [3:0] ErrUnterm      = 4'd11;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChSpace     = 8'h20;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] result_kind;
    logic [3:0] error_code;
    logic       end_of_run;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] entry;
    logic [CountW-1:0]        count;
  } bundle_t;

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c inside {[8'h30:8'h39]}) d = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) d = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) d = 5'(c - 8'h37);
    return d;
  endfunction

  // Bit 8 set marks a valid simple escape.
  function automatic logic [8:0] esc_map(logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22: r = {1'b1, 8'h22};
      8'h5c: r = {1'b1, 8'h5c};
      8'h2f: r = {1'b1, 8'h2f};
      8'h62: r = {1'b1, 8'h08};
      8'h66: r = {1'b1, 8'h0c};
      8'h6e: r = {1'b1, 8'h0a};
      8'h72: r = {1'b1, 8'h0d};
      8'h74: r = {1'b1, 8'h09};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

  function automatic bundle_t push(bundle_t b, logic [7:0] byt, logic [1:0] kind,
                                   logic [3:0] err);
    bundle_t r;
    r = b;
    if (r.count < CountW'(MaxResults)) begin
      r.entry[r.count[IdxW-1:0]].out_byte = byt;
      r.entry[r.count[IdxW-1:0]].result_kind = kind;
      r.entry[r.count[IdxW-1:0]].error_code = err;
      r.entry[r.count[IdxW-1:0]].end_of_run = 1'b0;
      r.count = r.count + 1'b1;
    end
    return r;
  endfunction

  function automatic bundle_t push_utf8(bundle_t b, logic [20:0] v);
    bundle_t r;
    r = b;
    if (v <= 21'h7f) begin
      r = push(r, v[7:0], KindByte, ErrNone);
    end else if (v <= 21'h7ff) begin
      r = push(r, {3'b110, v[10:6]}, KindByte, ErrNone);
      r = push(r, {2'b10, v[5:0]}, KindByte, ErrNone);
    end else if (v <= 21'hffff) begin
      r = push(r, {4'b1110, v[15:12]}, KindByte, ErrNone);
      r = push(r, {2'b10, v[11:6]}, KindByte, ErrNone);
      r = push(r, {2'b10, v[5:0]}, KindByte, ErrNone);
    end else begin
      r = push(r, {5'b11110, v[20:18]}, KindByte, ErrNone);
      r = push(r, {2'b10, v[17:12]}, KindByte, ErrNone);
      r = push(r, {2'b10, v[11:6]}, KindByte, ErrNone);
      r = push(r, {2'b10, v[5:0]}, KindByte, ErrNone);
    end
    return r;
  endfunction

endpackage

// ----- rtl/jsu_text_if.sv -----
// Interface: input byte channel of the JSON string decoder.
interface jsu_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output first_byte, output final_byte,
                  input ready);
  modport sink (input valid, input text_byte, input first_byte, input final_byte,
                output ready);
endinterface

// ----- rtl/jsu_result_if.sv -----
// Interface: result channel of the JSON string decoder.
interface jsu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [3:0] error_code;
  logic       end_of_run;

  modport source (output valid, output out_byte, output result_kind, output error_code,
                  output end_of_run, input ready);
  modport sink (input valid, input out_byte, input result_kind, input error_code,
                input end_of_run, output ready);
endinterface

// ----- rtl/jsu_decode.sv -----
// Decoder state and per-byte result generation for the JSON string decoder.
module jsu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      text_byte,
  input  logic            first_byte,
  input  logic            final_byte,
  output jsu_pkg::bundle_t bundle
);
  import jsu_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [15:0] code_accum, code_accum_next;
  logic [9:0]  high_half, high_half_next;
  logic [3:0]  pending_error, pending_error_next;

  always_comb begin
    phase_t     ph;
    logic [1:0] dc;
    logic [15:0] acc;
    logic [9:0] hh;
    logic [3:0] pe;
    logic [4:0] d;
    logic       grp_done;
    logic [8:0] esc;
    bundle_t    b;

    ph = phase;
    dc = digit_count;
    acc = code_accum;
    hh = high_half;
    pe = pending_error;
    d = 5'd0;
    grp_done = 1'b0;
    esc = esc_map(text_byte);
    b = '0;

    if (first_byte) begin
      ph = PhSkip;
      dc = 2'd0;
      acc = 16'd0;
      hh = 10'd0;
      pe = ErrNone;
    end

    case (ph)
      PhSkip: begin
        if (text_byte == ChQuote) begin
          ph = PhBody;
        end else if (!(text_byte == ChSpace || text_byte inside {[8'h09:8'h0d]})) begin
          b = push(b, 8'd0, KindErr, ErrNoQuote);
          ph = PhIdle;
        end
      end
      PhBody: begin
        if (text_byte == ChQuote) begin
          b = push(b, 8'd0, KindDone, ErrNone);
          ph = PhIdle;
        end else if (text_byte < ChSpace) begin
          b = push(b, 8'd0, KindErr, ErrControl);
          ph = PhIdle;
        end else if (text_byte == ChBackslash) begin
          ph = PhEsc;
        end else begin
          b = push(b, text_byte, KindByte, ErrNone);
        end
      end
      PhEsc: begin
        if (text_byte == ChU) begin
          dc = 2'd0;
          acc = 16'd0;
          pe = ErrNone;
          ph = PhHex1;
        end else if (!esc[8]) begin
          b = push(b, 8'd0, KindErr, ErrBadEsc);
          ph = PhIdle;
        end else begin
          b = push(b, esc[7:0], KindByte, ErrNone);
          ph = PhBody;
        end
      end
      PhHex1, PhHex2: begin
        d = hex_value(text_byte);
        if (d[4]) begin
          if (pe == ErrNone) pe = ErrBadHex;
          d = 5'd0;
        end
        acc = {acc[11:0], d[3:0]};
        grp_done = (dc == 2'd3);
        dc = dc + 2'd1;
        if (grp_done) begin
          if (pe != ErrNone) begin
            b = push(b, 8'd0, KindErr, pe);
            ph = PhIdle;
          end else if (ph == PhHex1) begin
            if (acc inside {[16'hd800:16'hdbff]}) begin
              hh = acc[9:0];
              ph = PhLowBs;
            end else if (acc inside {[16'hdc00:16'hdfff]}) begin
              b = push(b, 8'd0, KindErr, ErrLoneLow);
              ph = PhIdle;
            end else if (acc == 16'd0) begin
              b = push(b, 8'd0, KindErr, ErrNul);
              ph = PhIdle;
            end else begin
              b = push_utf8(b, 21'(acc));
              ph = PhBody;
            end
          end else begin
            if (!(acc inside {[16'hdc00:16'hdfff]})) begin
              b = push(b, 8'd0, KindErr, ErrBadLow);
              ph = PhIdle;
            end else begin
              b = push_utf8(b, 21'h10000 + 21'({hh, acc[9:0]}));
              ph = PhBody;
            end
          end
        end
      end
      PhLowBs: begin
        if (text_byte == ChBackslash) begin
          ph = PhLowU;
        end else begin
          b = push(b, 8'd0, KindErr, ErrMissingLow);
          ph = PhIdle;
        end
      end
      PhLowU: begin
        if (text_byte == ChU) begin
          dc = 2'd0;
          acc = 16'd0;
          pe = ErrNone;
          ph = PhHex2;
        end else begin
          b = push(b, 8'd0, KindErr, ErrMissingLow);
          ph = PhIdle;
        end
      end
      default: ph = PhIdle;
    endcase

    if (final_byte && ph != PhIdle) begin
      case (ph)
        PhSkip:  b = push(b, 8'd0, KindErr, ErrNoQuote);
        PhBody:  b = push(b, 8'd0, KindErr, ErrUnterm);
        PhEsc:   b = push(b, 8'd0, KindErr, ErrTruncEsc);
        PhHex1:  b = push(b, 8'd0, KindErr, ErrTruncUni);
        default: b = push(b, 8'd0, KindErr, ErrMissingLow);
      endcase
      ph = PhIdle;
    end

    for (int i = 0; i < MaxResults; i++) begin
      b.entry[i].end_of_run = (b.count != '0) && (b.count - 1'b1 == CountW'(i));
    end

    bundle = b;
    phase_next = ph;
    digit_count_next = dc;
    code_accum_next = acc;
    high_half_next = hh;
    pending_error_next = pe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhIdle;
      digit_count <= 2'd0;
      code_accum <= 16'd0;
      high_half <= 10'd0;
      pending_error <= ErrNone;
    end else if (accept) begin
      phase <= phase_next;
      digit_count <= digit_count_next;
      code_accum <= code_accum_next;
      high_half <= high_half_next;
      pending_error <= pending_error_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (phase == PhIdle || phase == PhHex1 || phase == PhHex2) || digit_count == 2'd0)
    else $error("digit count left nonzero outside a hex group");

  assert property (@(posedge clk) disable iff (rst)
    pending_error == ErrNone || pending_error == ErrBadHex)
    else $error("unexpected pending error code");

  assert property (@(posedge clk) disable iff (rst)
    accept && !final_byte && !first_byte && phase == PhIdle |-> bundle.count == '0)
    else $error("idle byte produced a result");

endmodule

// ----- rtl/json_string_unescape_utf8.sv -----
// Top level: JSON string literal decoder emitting UTF-8 bytes.
// Results of a byte go to the result buffer, then one at a time to the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the output
//   is not stalled; a byte that yields more than one result (up to five) holds the input
//   until the result buffer drains into the output register, one result per unstalled cycle.
// Reset: rst (synchronous) sets the decoder idle and empties the result buffer and output.
module json_string_unescape_utf8 (
  input logic        clk,
  input logic        rst,
  jsu_text_if.sink   text,
  jsu_result_if.source result
);
  import jsu_pkg::*;

  bundle_t           dec_bundle;
  result_t [MaxResults-1:0] entry;
  logic [CountW-1:0] count;
  logic [IdxW-1:0]   idx;
  logic              accept;
  logic              move;
  logic              last_take;
  logic              out_valid;
  result_t           out_data;

  assign move = (count != '0) && (!out_valid || result.ready);
  assign last_take = move && (CountW'(idx) + 1'b1 == count);
  assign text.ready = (count == '0) || last_take;
  assign accept = text.valid && text.ready;

  jsu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text.text_byte),
    .first_byte (text.first_byte),
    .final_byte (text.final_byte),
    .bundle     (dec_bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
    end else if (accept) begin
      count <= dec_bundle.count;
      idx <= '0;
    end else if (last_take) begin
      count <= '0;
      idx <= '0;
    end else if (move) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) entry <= dec_bundle.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) out_data <= entry[idx];
  end

  assign result.valid = out_valid;
  assign result.out_byte = out_data.out_byte;
  assign result.result_kind = out_data.result_kind;
  assign result.error_code = out_data.error_code;
  assign result.end_of_run = out_data.end_of_run;

  assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxResults) && (count == '0 || CountW'(idx) < count))
    else $error("result buffer index out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind != KindByte |-> out_data.end_of_run)
    else $error("completion or error is not the last result of its byte");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.result_kind == KindErr) == (out_data.error_code != ErrNone)))
    else $error("error code disagrees with result kind");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind != KindByte |-> out_data.out_byte == 8'd0)
    else $error("nonzero byte on a status result");

endmodule
